### rtl/ppcf_pkg.sv
// ----------------------------------------------------------------------------
// ppcf_pkg
// shared types and constants of the printer port character filter
// ----------------------------------------------------------------------------
package ppcf_pkg;

    localparam int BYTE_W   = 8;
    localparam int PAUSE_W  = 10;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 10;

    // default tab stop and the longest run that one tab may cause
    localparam int TAB_STOP_DEF = 8;
    localparam int MAX_RESULTS  = 8;
    localparam int RUN_CNT_W    = $clog2(MAX_RESULTS);

    // register indexes
    localparam logic [CFG_IW-1:0] REG_TRANSPARENT = 3'd0;
    localparam logic [CFG_IW-1:0] REG_HOST_ATT    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_ODD_PARITY  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_LINE_PAUSE  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PAGE_PAUSE  = 3'd4;

    // register reset values
    localparam logic               RST_TRANSPARENT = 1'b0;
    localparam logic               RST_HOST_ATT    = 1'b0;
    localparam logic               RST_ODD_PARITY  = 1'b1;
    localparam logic [PAUSE_W-1:0] RST_LINE_PAUSE  = 10'd15;
    localparam logic [PAUSE_W-1:0] RST_PAGE_PAUSE  = 10'd90;

    // character codes
    localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] LOW7_MSK = 8'h7F;
    localparam logic [BYTE_W-1:0] COL_MAX  = 8'hFF;

    // controller to datapath
    typedef struct packed {
        logic load_byte;   // load the accepted word into the output register
        logic load_space;  // load one tab space
        logic space_last;  // that space closes the run
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tab;      // input word expands into spaces
        logic is_drop;     // input word gives no result
        logic stop_next;   // one more column step lands on a tab stop
        logic out_free;    // output register can take a word this cycle
    } t_dp_sts;

endpackage

### rtl/ppcf_ctrl.sv
// ----------------------------------------------------------------------------
// ppcf_ctrl
// sequencer: accepts input words and, while the output is free, steps tab runs one space a cycle
// ----------------------------------------------------------------------------
module ppcf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ppcf_pkg::t_dp_sts i_sts,
    output ppcf_pkg::t_dp_cmd o_cmd
);
    import ppcf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_TAB  = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [RUN_CNT_W-1:0] r_cnt, n_cnt;
    logic                 w_accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_sts.out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_sts.is_tab) begin
                        o_cmd.load_space = 1'b1;
                        o_cmd.space_last = i_sts.stop_next;
                        n_cnt            = RUN_CNT_W'(1);
                        if (!i_sts.stop_next) begin
                            n_state = S_TAB;
                        end
                    end else if (!i_sts.is_drop) begin
                        o_cmd.load_byte = 1'b1;
                    end
                end
            end
            S_TAB: begin
                if (i_sts.out_free) begin
                    o_cmd.load_space = 1'b1;
                    o_cmd.space_last = i_sts.stop_next ||
                                       (r_cnt == RUN_CNT_W'(MAX_RESULTS - 1));
                    n_cnt            = r_cnt + RUN_CNT_W'(1);
                    if (o_cmd.space_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### rtl/ppcf_dp.sv
// ----------------------------------------------------------------------------
// ppcf_dp
// datapath: configuration, column tracking, parity, pause and output register
// ----------------------------------------------------------------------------
module ppcf_dp #(
    parameter int TAB_STOP = ppcf_pkg::TAB_STOP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppcf_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [ppcf_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic [ppcf_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_out_stall,
    input  ppcf_pkg::t_dp_cmd             i_cmd,
    output ppcf_pkg::t_dp_sts             o_sts,
    output logic                          o_out_valid,
    output logic [ppcf_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [ppcf_pkg::PAUSE_W-1:0]  o_pause_ticks,
    output logic                          o_last_of_run
);
    import ppcf_pkg::*;

    localparam int MOD_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam logic [MOD_W-1:0] MOD_TOP = MOD_W'(TAB_STOP - 1);

    logic               r_transparent, r_host_att, r_odd_parity;
    logic [PAUSE_W-1:0] r_line_pause, r_page_pause;

    // column and column modulo tab stop, kept in step
    logic [BYTE_W-1:0]  r_col, n_col;
    logic [MOD_W-1:0]   r_mod, n_mod;
    logic [MOD_W-1:0]   w_mod_inc;

    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic [PAUSE_W-1:0] r_pause, n_pause;
    logic               r_last, n_last;

    logic               w_interp;
    logic [BYTE_W-1:0]  w_par_byte, w_space, w_key;

    function automatic logic [BYTE_W-1:0] f_parity(input logic [BYTE_W-1:0] c,
                                                   input logic en);
        logic [BYTE_W-1:0] r;
        if (en) begin
            r = {~^c[6:0], c[6:0]};
        end else begin
            r = c;
        end
        return r;
    endfunction

    assign w_interp   = !r_transparent && r_host_att;
    assign w_par_byte = f_parity(i_in_byte, r_odd_parity);
    assign w_space    = f_parity(CH_SPACE, r_odd_parity);
    assign w_key      = r_odd_parity ? (w_par_byte & LOW7_MSK) : w_par_byte;
    assign w_mod_inc  = ((r_col == COL_MAX) || (r_mod == MOD_TOP)) ? '0
                                                                   : r_mod + MOD_W'(1);

    always_comb begin
        o_sts.is_tab    = w_interp && (i_in_byte == CH_TAB);
        o_sts.is_drop   = w_interp && (i_in_byte < CH_SPACE) &&
                          (i_in_byte != CH_CR) && (i_in_byte != CH_FF) &&
                          (i_in_byte != CH_LF) && (i_in_byte != CH_VT) &&
                          (i_in_byte != CH_BEL) && (i_in_byte != CH_BS) &&
                          (i_in_byte != CH_TAB);
        o_sts.stop_next = (w_mod_inc == '0);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_col       = r_col;
        n_mod       = r_mod;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_pause     = r_pause;
        n_last      = r_last;
        if (i_cmd.load_space) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_space;
            n_pause     = '0;
            n_last      = i_cmd.space_last;
            n_col       = r_col + BYTE_W'(1);
            n_mod       = w_mod_inc;
        end else if (i_cmd.load_byte) begin
            n_out_valid = 1'b1;
            n_last      = 1'b1;
            n_pause     = '0;
            if (r_transparent) begin
                n_out_byte = i_in_byte;
            end else begin
                n_out_byte = w_par_byte;
            end
            if (w_interp) begin
                if ((w_key == CH_VT) || (w_key == CH_FF)) begin
                    n_pause = r_page_pause;
                end else if (w_key == CH_LF) begin
                    n_pause = r_line_pause;
                end
                case (i_in_byte)
                    CH_CR, CH_FF: begin
                        n_col = '0;
                        n_mod = '0;
                    end
                    CH_LF, CH_VT, CH_BEL: begin
                        n_col = r_col;
                    end
                    CH_BS: begin
                        if (r_col != '0) begin
                            n_col = r_col - BYTE_W'(1);
                            n_mod = (r_mod == '0) ? MOD_TOP : r_mod - MOD_W'(1);
                        end
                    end
                    default: begin
                        n_col = r_col + BYTE_W'(1);
                        n_mod = w_mod_inc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transparent <= RST_TRANSPARENT;
            r_host_att    <= RST_HOST_ATT;
            r_odd_parity  <= RST_ODD_PARITY;
            r_line_pause  <= RST_LINE_PAUSE;
            r_page_pause  <= RST_PAGE_PAUSE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRANSPARENT: r_transparent <= i_cfg_data[0];
                REG_HOST_ATT:    r_host_att    <= i_cfg_data[0];
                REG_ODD_PARITY:  r_odd_parity  <= i_cfg_data[0];
                REG_LINE_PAUSE:  r_line_pause  <= i_cfg_data[PAUSE_W-1:0];
                REG_PAGE_PAUSE:  r_page_pause  <= i_cfg_data[PAUSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_mod       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_mod       <= n_mod;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_pause    <= n_pause;
        r_last     <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_pause_ticks = r_pause;
    assign o_last_of_run = r_last;

endmodule

### rtl/printer_port_char_filter.sv
// ----------------------------------------------------------------------------
// printer_port_char_filter
// filters words bound for a serial printer: control codes, tabs, parity, pauses
// ----------------------------------------------------------------------------
// an accepted input word has its result in the output register in the next cycle
// throughput: one input word a cycle while the output is not stalled; a tab expands into
//   up to eight spaces and holds the input for all but the first, set by the sequencer
// a stalled output register holds the input off until it is taken
// reset: synchronous, active low; clears column, output valid and sequencer,
//   and loads the configuration defaults
// ----------------------------------------------------------------------------
module printer_port_char_filter #(
    parameter int TAB_STOP = ppcf_pkg::TAB_STOP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ppcf_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [ppcf_pkg::CFG_DW-1:0]   i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ppcf_pkg::BYTE_W-1:0]   i_in_byte,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ppcf_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [ppcf_pkg::PAUSE_W-1:0]  o_pause_ticks,
    output logic                          o_last_of_run
);
    import ppcf_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: idle or stepping a tab run
    ppcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: registers, column, output word
    ppcf_dp #(
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_byte     (i_in_byte),
        .i_out_stall   (i_out_stall),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_pause_ticks (o_pause_ticks),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### rtl/ppcf_chk.sv
// ----------------------------------------------------------------------------
// ppcf_chk
// port checker for the printer port character filter
// ----------------------------------------------------------------------------
module ppcf_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ppcf_pkg::BYTE_W-1:0]   o_out_byte,
    input logic [ppcf_pkg::PAUSE_W-1:0]  o_pause_ticks,
    input logic                          o_last_of_run
);
    import ppcf_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) &&
        $stable(o_pause_ticks) && $stable(o_last_of_run))
        else $error("stalled output word changed");

    // only tab spaces come before the end of a run
    a_mid_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> (o_out_byte == CH_SPACE) &&
        (o_pause_ticks == '0))
        else $error("word inside a run is not a plain space");

    // input is held off while a run is open
    a_mid_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_in_stall)
        else $error("input taken during a tab run");

    // a pause only comes with the last word of a run
    a_pause_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_pause_ticks != '0) |-> o_last_of_run)
        else $error("pause on a word that is not last of run");

endmodule

bind printer_port_char_filter ppcf_chk u_ppcf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_pause_ticks (o_pause_ticks),
    .o_last_of_run (o_last_of_run)
);
